FILE: hdl/sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue top level.
// Depends on nothing; included inside the top-level module body.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Sorted priority queue check failed.");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Sorted priority queue check failed.");

`endif

FILE: hdl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// Used by the cell, the response buffer and the top level; depends on nothing.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FILL_W       = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] popped_priority;
        logic                     is_empty;
        logic [FILL_W-1:0]        fill_count;
    } t_rsp;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry entry;
    } t_cell_cmd;

endpackage

FILE: hdl/spq_cell.sv
// One slot of the sorted row: holds a value/priority pair and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,
    input  logic               i_prev_keep,
    input  spq_pkg::t_entry    i_prev_entry,
    input  spq_pkg::t_entry    i_next_entry,
    output logic               o_keep,
    output spq_pkg::t_entry    o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An occupied slot of strictly higher priority stays where it is on an insert.
    assign o_keep  = i_occupied && (r_entry.prio > i_cmd.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert && !o_keep) begin
            n_entry = i_prev_keep ? i_cmd.entry : i_prev_entry;
        end else if (i_cmd.remove) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: hdl/spq_skid.sv
// Two-deep response buffer: an output register and a skid register behind it.
// Depends on spq_pkg.
module spq_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  spq_pkg::t_rsp i_data,
    output logic          o_ready,
    output logic          o_valid,
    output spq_pkg::t_rsp o_data,
    input  logic          i_ready
);
    import spq_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_rsp r_out;
    t_rsp r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

FILE: hdl/sorted_priority_queue_top.sv
// Channel   Direction  Payload  Handshake
// request   in         t_req    i_req_valid / o_req_ready
// response  out        t_rsp    o_rsp_valid / i_rsp_ready
//
// All cells compare against the new priority at once and the whole row shifts or holds in
// the same clock edge, so one request per cycle while the skid register is free.
// Each response is registered in the output register, or in the skid register on a stall.
// A stalled response is held while one more request goes into the skid register.
// Reset clears the entry count and the response valids; slot contents are not cleared.
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  spq_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output spq_pkg::t_rsp o_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             req_fire;
    logic             is_full;
    logic             is_none;
    t_cell_cmd        cell_cmd;
    t_rsp             rsp;
    t_entry           entries [CAPACITY];
    logic             keeps   [CAPACITY];

    assign req_fire = i_req_valid && o_req_ready;
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_none  = (r_count == '0);

    always_comb begin
        cell_cmd.insert      = req_fire && (i_req.req_type == REQ_INSERT) && !is_full;
        cell_cmd.remove      = req_fire && (i_req.req_type == REQ_REMOVE) && !is_none;
        cell_cmd.entry.value = i_req.item_value;
        cell_cmd.entry.prio  = i_req.item_priority;
    end

    always_comb begin
        n_count             = r_count;
        rsp.status          = ST_OK;
        rsp.popped_value    = '0;
        rsp.popped_priority = '0;
        if (i_req.req_type == REQ_INSERT) begin
            if (is_full) begin
                rsp.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (is_none) begin
                rsp.status = ST_EMPTY;
            end else begin
                n_count             = r_count - CNT_W'(1);
                rsp.popped_value    = entries[0].value;
                rsp.popped_priority = entries[0].prio;
            end
        end
        rsp.is_empty   = (n_count == '0);
        rsp.fill_count = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (req_fire) begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   prev_keep;
        t_entry prev_entry;
        t_entry next_entry;

        if (g == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_entry = cell_cmd.entry;
        end else begin : g_body
            assign prev_keep  = keeps[g-1];
            assign prev_entry = entries[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_entry = entries[g];
        end else begin : g_link
            assign next_entry = entries[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cell_cmd),
            .i_occupied   (r_count > CNT_W'(g)),
            .i_prev_keep  (prev_keep),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_keep       (keeps[g]),
            .o_entry      (entries[g])
        );
    end

    spq_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_fire),
        .i_data  (rsp),
        .o_ready (o_req_ready),
        .o_valid (o_rsp_valid),
        .o_data  (o_rsp),
        .i_ready (i_rsp_ready)
    );

`include "sorted_priority_queue_top_assert.svh"

    `SPQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, cell_cmd.remove,
        r_count == CNT_W'($past(r_count) - CNT_W'(1)))
    `SPQ_ASSERT_SAME(a_head_order, i_clk, i_rst_n, r_count >= CNT_W'(2),
        entries[0].prio >= entries[1].prio)
    `SPQ_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, !o_req_ready, o_rsp_valid)

endmodule

FILE: dv/sorted_priority_queue_top_tb.sv
// Testbench for sorted_priority_queue_top: directed and random insert/remove traffic
// checked against a sorted-list predictor with random idling on both channels.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
module sorted_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = CAPACITY_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    t_entry sorted_entries[$];
    t_rsp pending_rsps[$];
    int mismatch_count = 0;
    bit no_idle_stretch = 1'b0;

    sorted_priority_queue_top #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp(o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle_stretch || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] random_priority();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4, 5: return int'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_req(input int insert_pct);
        t_req req;
        req.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        req.item_value = $urandom;
        req.item_priority = random_priority();
        return req;
    endfunction

    function automatic t_rsp predict_rsp(input t_req req);
        t_rsp rsp;
        t_entry fresh;
        int pos;
        rsp = '0;
        rsp.status = ST_OK;
        if (req.req_type == REQ_INSERT) begin
            if (sorted_entries.size() >= QUEUE_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_entries.size()
                       && $signed(sorted_entries[pos].prio) > $signed(req.item_priority)) begin
                    pos++;
                end
                fresh.value = req.item_value;
                fresh.prio = req.item_priority;
                sorted_entries.insert(pos, fresh);
            end
        end else if (sorted_entries.size() == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            fresh = sorted_entries.pop_front();
            rsp.popped_value = fresh.value;
            rsp.popped_priority = fresh.prio;
        end
        rsp.is_empty = (sorted_entries.size() == 0);
        rsp.fill_count = FILL_W'(sorted_entries.size());
        return rsp;
    endfunction

    // Called at a rising edge; returns at the edge where the request is accepted.
    task automatic send_req(input t_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= req;
        do begin
            @(posedge i_clk);
        end while (!o_req_ready);
        pending_rsps.push_back(predict_rsp(req));
    endtask

    task automatic insert_pair(input logic signed [DATA_W-1:0] value,
                               input logic signed [DATA_W-1:0] prio);
        t_req req;
        req.req_type = REQ_INSERT;
        req.item_value = value;
        req.item_priority = prio;
        send_req(req);
    endtask

    task automatic remove_top();
        t_req req;
        req = random_req(0);
        send_req(req);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : rsp_checker
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch($sformatf("response with no request pending, status %0d",
                                          o_rsp.status));
            end else begin
                want = pending_rsps.pop_front();
                check_field("status", 32'(o_rsp.status), 32'(want.status));
                check_field("popped_value", o_rsp.popped_value, want.popped_value);
                check_field("popped_priority", o_rsp.popped_priority, want.popped_priority);
                check_field("is_empty", 32'(o_rsp.is_empty), 32'(want.is_empty));
                check_field("fill_count", 32'(o_rsp.fill_count), 32'(want.fill_count));
            end
        end
    end

    initial begin : rsp_ready_driver
        int run_len;
        int stall_len;
        forever begin
            run_len = $urandom_range(1, 12);
            i_rsp_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    task automatic test_remove_when_empty();
        remove_top();
    endtask

    task automatic test_fill_and_overflow();
        int k;
        insert_pair(32'h7FFF_FFFF, 0);
        insert_pair(32'h8000_0000, 0);
        insert_pair(0, 32'h7FFF_FFFF);
        insert_pair(-1, 32'h8000_0000);
        insert_pair(32'h5555_5555, 32'h7FFF_FFFF);
        insert_pair(32'hAAAA_AAAA, 32'h8000_0000);
        insert_pair(1, -1);
        insert_pair(2, 1);
        insert_pair(3, 1);
        insert_pair(4, -1);
        for (k = 0; k < QUEUE_DEPTH - 10; k++) begin
            insert_pair($urandom, random_priority());
        end
        insert_pair(32'h1234_5678, 32'h7FFF_FFFF);
    endtask

    task automatic test_ordered_drain();
        repeat (6) remove_top();
    endtask

    task automatic run_random(input int count, input int insert_pct);
        int k;
        for (k = 0; k < count; k++) begin
            if (k % 64 == 0) begin
                no_idle_stretch = ($urandom_range(0, 3) == 0);
            end
            send_req(random_req(insert_pct));
        end
        no_idle_stretch = 1'b0;
    endtask

    task automatic test_balanced_traffic();
        run_random(1100, 50);
    endtask

    task automatic test_overflow_traffic();
        run_random(350, 80);
    endtask

    task automatic test_underflow_traffic();
        run_random(350, 25);
    endtask

    initial begin : main_sequence
        int settle;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_remove_when_empty();
        test_fill_and_overflow();
        test_ordered_drain();
        test_balanced_traffic();
        test_overflow_traffic();
        test_underflow_traffic();
        i_req_valid <= 1'b0;
        while (pending_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        for (settle = 0; settle < 8; settle++) begin
            @(posedge i_clk);
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : run_limit
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sorted_priority_queue_top.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/spq_skid.sv
hdl/sorted_priority_queue_top.sv
dv/sorted_priority_queue_top_tb.sv
